FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker module of the UTF-8 stream decoder.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UTS_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define UTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/uts_pkg.sv
// Shared types and constants of the UTF-8 stream decoder.
// No dependencies; imported by every module of the block.
package uts_pkg;

  // Field widths.
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CpW      = 21;
  localparam int unsigned UsedW    = 3;
  localparam int unsigned RepW     = 3;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 32;

  // Depth of the job queue between the front and the back.
  localparam int unsigned QueueDepth = 2;

  // Replacement character '?'.
  localparam logic [CpW-1:0] ReplChar = 21'd63;

  // One decoded input byte: some replacements, then an optional code point.
  typedef struct packed {
    logic [RepW-1:0]  n_rep;
    logic             tail_v;
    logic [CpW-1:0]   tail_cp;
    logic [UsedW-1:0] tail_used;
  } uts_job_t;

endpackage

FILE: hw/rtl/utf8_stream_decoder.sv
// UTF-8 stream decoder.
//
// Input channel (s_*): one text byte per transaction in s_tdata_i[7:0];
// s_tlast_i marks the last byte of a text and flushes any open sequence.
// Output channel (m_*): one result per transaction; m_tdata_o carries the
// code point, the bytes it consumed and a replacement flag, and m_tlast_o
// marks the last result caused by one input byte. A continuation byte of an
// unfinished sequence gives no result; a broken sequence gives up to four.
// Throughput: one byte per cycle while the queue has room, limited by the back,
// which sends one result per cycle unless the receiver stalls; a byte that
// causes k results holds the back until all k are sent. The first result of
// a byte is registered in the job queue at the byte's transaction edge and
// then loaded from the head of the queue into the output register.
// When the receiver stalls, the output register holds its result and the
// two-entry job queue fills; s_tready_o falls only once the queue is full.
// Reset clears the pending sequence, the queue pointers and count, and the output valid flag.
// Files: uts_pkg, uts_queue, uts_front, uts_back.
module utf8_stream_decoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid_i,
  output logic                          s_tready_o,
  input  logic [uts_pkg::InDataW-1:0]   s_tdata_i,   // [7:0] text_byte
  input  logic                          s_tlast_i,   // final_byte
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  // [20:0] code_point, [23:21] bytes_used, [24] replaced, [31:25] zero
  output logic [uts_pkg::OutDataW-1:0]  m_tdata_o,
  output logic                          m_tlast_o    // last_of_run
);
  import uts_pkg::*;

  logic     push_valid, push_ready, pop_valid, pop_ready;
  uts_job_t push_job, pop_job;

  uts_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .s_tlast_i   (s_tlast_i),
    .job_valid_o (push_valid),
    .job_ready_i (push_ready),
    .job_o       (push_job)
  );

  uts_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_job)
  );

  uts_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (pop_valid),
    .job_ready_o (pop_ready),
    .job_i       (pop_job),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .m_tlast_o   (m_tlast_o)
  );

endmodule

FILE: hw/rtl/uts_queue.sv
// Small job queue that decouples the byte front from the result back.
// Depends on uts_pkg for the job type.
module uts_queue #(
  parameter int unsigned Depth = uts_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  uts_pkg::uts_job_t push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output uts_pkg::uts_job_t pop_data_o
);
  import uts_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  uts_job_t        mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign push_ready_o = (cnt_q != FullCnt);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // Pointer and fill count update.
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

FILE: hw/rtl/uts_front.sv
// Front of the UTF-8 stream decoder: accepts bytes, tracks the pending
// sequence and turns each byte into a job. Depends on uts_pkg.
module uts_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_tvalid_i,
  output logic                         s_tready_o,
  input  logic [uts_pkg::InDataW-1:0]  s_tdata_i,
  input  logic                         s_tlast_i,
  output logic                         job_valid_o,
  input  logic                         job_ready_i,
  output uts_pkg::uts_job_t            job_o
);
  import uts_pkg::*;

  typedef enum logic [2:0] {
    ClsAscii,
    ClsCont,
    ClsLead2,
    ClsLead3,
    ClsLead4,
    ClsInvalid
  } byte_cls_e;

  logic [CpW-1:0]   part_q, part_d;
  logic [1:0]       need_q, need_d;
  logic [1:0]       held_q, held_d;
  logic [ByteW-1:0] b;
  logic             fin, accept, fresh;
  logic [CpW-1:0]   part_sh;
  logic [RepW-1:0]  rep;
  byte_cls_e        cls;
  uts_job_t         job;

  assign b      = s_tdata_i[ByteW-1:0];
  assign fin    = s_tlast_i;
  assign accept = s_tvalid_i && s_tready_o;

  // A byte is taken whenever the queue has room.
  assign s_tready_o = job_ready_i;

  // Byte classification by its leading bits.
  always_comb begin
    if (!b[7]) begin
      cls = ClsAscii;
    end else if (b[7:6] == 2'b10) begin
      cls = ClsCont;
    end else if (b[7:5] == 3'b110) begin
      cls = ClsLead2;
    end else if (b[7:4] == 4'b1110) begin
      cls = ClsLead3;
    end else if (b[7:3] == 5'b11110) begin
      cls = ClsLead4;
    end else begin
      cls = ClsInvalid;
    end
  end

  assign part_sh = {part_q[CpW-7:0], b[5:0]};

  // Sequence tracking and job forming.
  always_comb begin
    part_d = part_q;
    need_d = need_q;
    held_d = held_q;
    job    = '0;
    fresh  = 1'b1;
    rep    = '0;

    if (need_q != 2'd0) begin
      if (cls == ClsCont) begin
        fresh = 1'b0;
        if (need_q == 2'd1) begin
          // Sequence complete.
          job.tail_v    = 1'b1;
          job.tail_cp   = part_sh;
          job.tail_used = {1'b0, held_q} + UsedW'(2);
          part_d = '0;
          need_d = 2'd0;
          held_d = 2'd0;
        end else if (fin) begin
          // Cut short: the lead byte and all held bytes, this one included.
          job.n_rep = {1'b0, held_q} + RepW'(2);
          part_d = '0;
          need_d = 2'd0;
          held_d = 2'd0;
        end else begin
          part_d = part_sh;
          need_d = need_q - 2'd1;
          held_d = held_q + 2'd1;
        end
      end else begin
        // Broken sequence: replace the lead and held bytes first.
        rep    = {1'b0, held_q} + RepW'(1);
        part_d = '0;
        need_d = 2'd0;
        held_d = 2'd0;
      end
    end

    if (fresh) begin
      unique case (cls)
        ClsAscii: begin
          job.tail_v    = 1'b1;
          job.tail_cp   = CpW'(b);
          job.tail_used = UsedW'(1);
        end
        ClsLead2, ClsLead3, ClsLead4: begin
          if (fin) begin
            rep = rep + RepW'(1);
          end else begin
            held_d = 2'd0;
            unique case (cls)
              ClsLead2: begin
                part_d = CpW'(b[4:0]);
                need_d = 2'd1;
              end
              ClsLead3: begin
                part_d = CpW'(b[3:0]);
                need_d = 2'd2;
              end
              default: begin
                part_d = CpW'(b[2:0]);
                need_d = 2'd3;
              end
            endcase
          end
        end
        default: begin
          // Stray continuation or invalid byte.
          rep = rep + RepW'(1);
        end
      endcase
      job.n_rep = rep;
    end
  end

  assign job_o       = job;
  assign job_valid_o = s_tvalid_i && ((job.n_rep != '0) || job.tail_v);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_q <= '0;
      need_q <= 2'd0;
      held_q <= 2'd0;
    end else if (accept) begin
      part_q <= part_d;
      need_q <= need_d;
      held_q <= held_d;
    end
  end

endmodule

FILE: hw/rtl/uts_back.sv
// Back of the UTF-8 stream decoder: expands each queued job into result
// transactions through the output register. Depends on uts_pkg.
module uts_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          job_valid_i,
  output logic                          job_ready_o,
  input  uts_pkg::uts_job_t             job_i,
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  output logic [uts_pkg::OutDataW-1:0]  m_tdata_o,
  output logic                          m_tlast_o
);
  import uts_pkg::*;

  logic                cnt_last;
  logic [RepW-1:0]     cnt_q, cnt_d;
  logic                vld_q, vld_d;
  logic [OutDataW-1:0] data_q, data_d;
  logic                last_q, last_d;
  logic                slot_free, emit, in_rep, res_last;
  logic [CpW-1:0]      cp;
  logic [UsedW-1:0]    used;

  // The output register can take a result when empty or being drained.
  assign slot_free = !vld_q || m_tready_i;
  assign emit      = job_valid_i && slot_free;

  // Replacements come first, then the optional code point.
  assign in_rep   = (cnt_q < job_i.n_rep);
  assign cnt_last = ((cnt_q + RepW'(1)) == job_i.n_rep);
  assign res_last = in_rep ? (cnt_last && !job_i.tail_v) : 1'b1;
  assign cp       = in_rep ? ReplChar : job_i.tail_cp;
  assign used     = in_rep ? UsedW'(1) : job_i.tail_used;

  assign job_ready_o = emit && res_last;

  always_comb begin
    vld_d  = slot_free ? emit : vld_q;
    data_d = OutDataW'({in_rep, used, cp});
    last_d = res_last;
    cnt_d  = cnt_q;
    if (emit) begin
      cnt_d = res_last ? '0 : cnt_q + RepW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      vld_q <= vld_d;
      cnt_q <= cnt_d;
    end
  end

  // Payload of the output register.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      data_q <= data_d;
      last_q <= last_d;
    end
  end

  assign m_tvalid_o = vld_q;
  assign m_tdata_o  = data_q;
  assign m_tlast_o  = last_q;

endmodule

FILE: hw/rtl/uts_checker.sv
// Port-level checker of the UTF-8 stream decoder and its bind statement.
// Depends on uts_pkg and assert_macros.svh.
`include "assert_macros.svh"

module uts_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_tvalid_i,
  input logic                          s_tready_o,
  input logic [uts_pkg::InDataW-1:0]   s_tdata_i,
  input logic                          s_tlast_i,
  input logic                          m_tvalid_o,
  input logic                          m_tready_i,
  input logic [uts_pkg::OutDataW-1:0]  m_tdata_o,
  input logic                          m_tlast_o
);
  import uts_pkg::*;

  // A stalled result transaction holds its payload.
  `UTS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_tvalid_o && !m_tready_i, m_tvalid_o && $stable(m_tdata_o) && $stable(m_tlast_o), "stalled result changed")

  // A replacement is always '?' for a single byte.
  `UTS_ASSERT_IMPLY(a_repl_form, clk_i, rst_ni, m_tvalid_o && m_tdata_o[24], (m_tdata_o[20:0] == ReplChar) && (m_tdata_o[23:21] == 3'd1), "bad replacement result")

  // A plain single-byte result stays below 0x80.
  `UTS_ASSERT_IMPLY(a_ascii_range, clk_i, rst_ni, m_tvalid_o && !m_tdata_o[24] && (m_tdata_o[23:21] == 3'd1), m_tdata_o[20:7] == '0, "single byte code point out of range")

  // A two-byte result carries at most eleven bits, and padding stays zero.
  `UTS_ASSERT_IMPLY(a_two_byte_range, clk_i, rst_ni, m_tvalid_o && (m_tdata_o[23:21] == 3'd2), (m_tdata_o[20:11] == '0) && (m_tdata_o[31:25] == '0), "two byte code point out of range")

endmodule

bind utf8_stream_decoder uts_checker u_uts_checker (.*);
